[rtl/mmcv_pkg.sv]
// Package for the monophonic MIDI note to CV unit.
// Word types, command and message codes, and the control structs of the slot chain.
// No dependencies.
`timescale 1ns / 1ps

package mmcv_pkg;

  localparam logic [1:0] CMD_MIDI  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_PANIC = 2'd2;

  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CTRL     = 4'hB;
  localparam logic [6:0] CC_ALL_OFF    = 7'h7B;
  localparam logic [1:0] PANIC_LEN     = 2'd3;

  localparam logic [1:0] REG_OCTAVE   = 2'd0;
  localparam logic [1:0] REG_SEMITONE = 2'd1;
  localparam logic [1:0] REG_CENT     = 2'd2;
  localparam logic [1:0] REG_RETRIG   = 2'd3;

  localparam logic signed [15:0] CENTS_OCTAVE   = 16'sd1200;
  localparam logic signed [15:0] CENTS_SEMITONE = 16'sd100;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic [1:0] message_length;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pitch_cents;
    logic [6:0]         velocity_level;
    logic               gate;
  } out_word_t;

  typedef struct packed {
    logic       clear;
    logic       note_on;
    logic       note_off;
    logic [6:0] note;
  } cell_ctl_t;

  typedef struct packed {
    logic       found;
    logic [6:0] note;
  } hi_link_t;

endpackage

[rtl/mono_midi_note_to_cv_unit.sv]
// Top level of the monophonic MIDI note to CV unit.
// Decodes input words, runs the slot chain and registers one result per tick.
// Depends on mmcv_pkg and mmcv_slot_cell.
`timescale 1ns / 1ps

// Takes one input word per cycle. A MIDI or panic word updates the slot chain
// and held note in the cycle it is accepted; a tick word loads the output
// register with pitch, velocity and gate. Input ready drops only while that
// output register holds a word that has not been taken, so the rate is one
// word per cycle when the output side keeps up. The first-free and
// highest-occupied searches ripple combinationally through SLOT_COUNT cells.

module mono_midi_note_to_cv_unit #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mmcv_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mmcv_pkg::out_word_t out_data,
  input  logic                cfg_wen,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import mmcv_pkg::*;

  logic [3:0] octave_offset;
  logic [4:0] semitone_offset;
  logic [7:0] cent_offset;
  logic       retrigger_enable;

  logic [6:0] current_note;
  logic [6:0] current_velocity;
  logic       retrigger_pending;

  logic       accept;
  logic [3:0] kind;
  logic       is_midi;
  logic       is_tick;
  logic       is_clear;
  cell_ctl_t  ctl;

  logic     [SLOT_COUNT:0] taken;
  hi_link_t [SLOT_COUNT:0] hi;

  logic               fire_retrig;
  logic signed [15:0] pitch;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign kind     = in_data.status_byte[7:4];
  assign is_midi  = accept && in_data.command == CMD_MIDI;
  assign is_tick  = accept && in_data.command == CMD_TICK;

  always_comb begin
    is_clear = (accept && in_data.command == CMD_PANIC) ||
               (is_midi && kind == KIND_CTRL && in_data.data_one == CC_ALL_OFF &&
                in_data.message_length == PANIC_LEN);
    ctl.clear    = is_clear;
    ctl.note_on  = is_midi && kind == KIND_NOTE_ON && in_data.data_two != 7'd0;
    ctl.note_off = is_midi && (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) &&
                   !ctl.note_on;
    ctl.note     = in_data.data_one;
  end

  assign taken[0] = 1'b0;
  assign hi[SLOT_COUNT] = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
    mmcv_slot_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .taken_in  (taken[i]),
      .taken_out (taken[i+1]),
      .hi_in     (hi[i+1]),
      .hi_out    (hi[i])
    );
  end

  assign fire_retrig = retrigger_pending && retrigger_enable;

  assign pitch = $signed({{12{octave_offset[3]}}, octave_offset}) * CENTS_OCTAVE
               + $signed({{11{semitone_offset[4]}}, semitone_offset}) * CENTS_SEMITONE
               + $signed({{8{cent_offset[7]}}, cent_offset})
               + $signed({9'd0, current_note}) * CENTS_SEMITONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_offset    <= '0;
      semitone_offset  <= '0;
      cent_offset      <= '0;
      retrigger_enable <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_OCTAVE:   octave_offset    <= cfg_data[3:0];
        REG_SEMITONE: semitone_offset  <= cfg_data[4:0];
        REG_CENT:     cent_offset      <= cfg_data;
        REG_RETRIG:   retrigger_enable <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || is_clear) begin
      current_note      <= '0;
      current_velocity  <= '0;
      retrigger_pending <= 1'b0;
    end else if (ctl.note_on) begin
      current_note      <= in_data.data_one;
      current_velocity  <= in_data.data_two;
      retrigger_pending <= 1'b1;
    end else if (ctl.note_off) begin
      if (hi[0].found) begin
        current_note <= hi[0].note;
      end
    end else if (is_tick) begin
      if (!hi[0].found) begin
        current_velocity <= '0;
      end
      if (fire_retrig) begin
        retrigger_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick) begin
      out_data.pitch_cents    <= pitch;
      out_data.velocity_level <= hi[0].found ? current_velocity : 7'd0;
      out_data.gate           <= hi[0].found && !fire_retrig;
    end
  end

endmodule

[rtl/mmcv_slot_cell.sv]
// One held-note slot of the chain: a valid bit and a note number.
// Passes the first-free claim upward and the note of the highest occupied slot downward.
// Depends on mmcv_pkg.
`timescale 1ns / 1ps

module mmcv_slot_cell (
  input  logic               clk,
  input  logic               rst,
  input  mmcv_pkg::cell_ctl_t ctl,
  input  logic               taken_in,
  output logic               taken_out,
  input  mmcv_pkg::hi_link_t hi_in,
  output mmcv_pkg::hi_link_t hi_out
);
  import mmcv_pkg::*;

  logic       valid;
  logic [6:0] note;
  logic       claim;
  logic       valid_after;

  assign claim       = ctl.note_on && !valid && !taken_in;
  assign taken_out   = taken_in || !valid;
  assign valid_after = valid && !(ctl.note_off && note == ctl.note);

  assign hi_out.found = hi_in.found || valid_after;
  assign hi_out.note  = hi_in.found ? hi_in.note : note;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (claim) begin
      valid <= 1'b1;
    end else begin
      valid <= valid_after;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      note <= ctl.note;
    end
  end

endmodule

[bench/tb_mono_midi_note_to_cv_unit.sv]
// Testbench for mono_midi_note_to_cv_unit: directed and random words under several register
// settings and idling patterns, each CV word checked against a note-table tracker.
// Depends on mmcv_pkg and the unit RTL.
`timescale 1ns / 1ps

import mmcv_pkg::*;

class cv_tracker #(int SLOTS = 8);
  logic signed [3:0] octave;
  logic signed [4:0] semitone;
  logic signed [7:0] cent;
  logic              retrig_en;
  logic [SLOTS-1:0]  slot_used;
  logic [6:0]        slot_note [SLOTS];
  logic [6:0]        held_note;
  logic [6:0]        held_vel;
  logic              retrig_due;
  out_word_t         cv_due [$];
  int                errors;

  function new();
    octave    = '0;
    semitone  = '0;
    cent      = '0;
    retrig_en = 1'b0;
    errors    = 0;
    clear_notes();
  endfunction

  function void clear_notes();
    slot_used = '0;
    foreach (slot_note[i]) slot_note[i] = '0;
    held_note  = '0;
    held_vel   = '0;
    retrig_due = 1'b0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [7:0] val);
    case (idx)
      REG_OCTAVE:   octave    = val[3:0];
      REG_SEMITONE: semitone  = val[4:0];
      REG_CENT:     cent      = val;
      REG_RETRIG:   retrig_en = val[0];
      default: ;
    endcase
  endfunction

  function void absorb_word(in_word_t w);
    logic [3:0] kind;
    logic       busy;
    int         sum;
    out_word_t  cv;
    kind = w.status_byte[7:4];
    case (w.command)
      CMD_MIDI: begin
        if (kind == KIND_CTRL && w.data_one == CC_ALL_OFF &&
            w.message_length == PANIC_LEN) begin
          clear_notes();
        end else if (kind == KIND_NOTE_ON && w.data_two != 7'd0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_note[i] = w.data_one;
              break;
            end
          end
          held_note  = w.data_one;
          held_vel   = w.data_two;
          retrig_due = 1'b1;
        end else if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_note[i] == w.data_one) slot_used[i] = 1'b0;
          end
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_used[i]) begin
              held_note = slot_note[i];
              break;
            end
          end
        end
      end
      CMD_TICK: begin
        busy = |slot_used;
        if (!busy) held_vel = '0;
        cv.gate = busy;
        if (retrig_due && retrig_en) begin
          retrig_due = 1'b0;
          cv.gate    = 1'b0;
        end
        sum = int'(octave) * int'(CENTS_OCTAVE) + int'(semitone) * int'(CENTS_SEMITONE)
            + int'(cent) + int'(held_note) * int'(CENTS_SEMITONE);
        cv.pitch_cents    = sum[15:0];
        cv.velocity_level = held_vel;
        cv_due.push_back(cv);
      end
      CMD_PANIC: clear_notes();
      default: ;
    endcase
  endfunction

  function void check_cv(out_word_t got);
    out_word_t want;
    if (cv_due.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected cv word: pitch %0d velocity %0d gate %0b",
                 got.pitch_cents, got.velocity_level, got.gate);
      end
      return;
    end
    want = cv_due.pop_front();
    if (got.pitch_cents !== want.pitch_cents || got.velocity_level !== want.velocity_level ||
        got.gate !== want.gate) begin
      errors++;
      if (errors <= 10) begin
        $display("cv mismatch: expected pitch %0d velocity %0d gate %0b, got %0d %0d %0b",
                 want.pitch_cents, want.velocity_level, want.gate,
                 got.pitch_cents, got.velocity_level, got.gate);
      end
    end
  endfunction
endclass

module tb_mono_midi_note_to_cv_unit;
  localparam int         IN_W          = $bits(in_word_t);
  localparam int         STALL_LIMIT   = 4000;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         PHASES        = 8;
  localparam int         PHASE_WORDS   = 170;
  localparam logic [1:0] CMD_IGNORED   = 2'd3;
  localparam logic [3:0] KIND_PRESSURE = 4'hA;
  localparam logic [3:0] KIND_SYSTEM   = 4'hF;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  in_word_t   in_data   = '0;
  logic       out_ready = 1'b0;
  logic       cfg_wen   = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;
  logic       in_ready;
  logic       out_valid;
  out_word_t  out_data;

  int   gap_pct   = 0;
  int   stall_pct = 0;
  int   hold_left = 0;
  int   quiet     = 0;
  logic hold_req  = 1'b0;
  cv_tracker tracker;

  mono_midi_note_to_cv_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_cv(out_data);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_word_t midi_word(logic [7:0] status, logic [6:0] d1, logic [6:0] d2,
                                         logic [1:0] len);
    in_word_t w;
    w.command        = CMD_MIDI;
    w.status_byte    = status;
    w.data_one       = d1;
    w.data_two       = d2;
    w.message_length = len;
    return w;
  endfunction

  function automatic in_word_t bare_word(logic [1:0] cmd);
    in_word_t w;
    w         = IN_W'($urandom);
    w.command = cmd;
    return w;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t    w;
    int unsigned pick;
    logic [6:0]  note;
    w    = IN_W'($urandom);
    pick = $urandom_range(99);
    note = ($urandom_range(3) == 0) ? 7'($urandom) : 7'(48 + $urandom_range(11));
    if (pick < 34) begin
      w.command = CMD_TICK;
    end else if (pick < 66) begin
      w.command     = CMD_MIDI;
      w.status_byte = {KIND_NOTE_ON, 4'($urandom)};
      w.data_one    = note;
      w.data_two    = 7'($urandom_range(127, 1));
    end else if (pick < 80) begin
      w.command     = CMD_MIDI;
      w.status_byte = {($urandom_range(1) == 0) ? KIND_NOTE_OFF : KIND_NOTE_ON, 4'($urandom)};
      w.data_one    = note;
      if (w.status_byte[7:4] == KIND_NOTE_ON) w.data_two = '0;
    end else if (pick < 84) begin
      w.command     = CMD_MIDI;
      w.status_byte = {KIND_CTRL, 4'($urandom)};
      w.data_one    = CC_ALL_OFF;
      if ($urandom_range(1) == 0) w.message_length = PANIC_LEN;
    end else if (pick < 86) begin
      w.command = CMD_PANIC;
    end else if (pick < 88) begin
      w.command = CMD_IGNORED;
    end
    return w;
  endfunction

  task automatic push_word(input in_word_t w);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.absorb_word(w);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  task automatic load_setting(input logic [7:0] oct_v, input logic [7:0] semi_v,
                              input logic [7:0] cent_v, input logic [7:0] retrig_v);
    put_reg(REG_OCTAVE, oct_v);
    put_reg(REG_SEMITONE, semi_v);
    put_reg(REG_CENT, cent_v);
    put_reg(REG_RETRIG, retrig_v);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_word(bare_word(CMD_TICK));
    push_word(midi_word({KIND_NOTE_ON, 4'h0}, 7'd127, 7'd127, PANIC_LEN));
    push_word(bare_word(CMD_TICK));
    push_word(midi_word({KIND_NOTE_ON, 4'hF}, 7'd0, 7'd1, 2'd1));
    push_word(midi_word({KIND_NOTE_OFF, 4'h3}, 7'd0, 7'd64, 2'd0));
    push_word(bare_word(CMD_TICK));
    push_word(midi_word({KIND_NOTE_ON, 4'h5}, 7'd127, 7'd0, 2'd2));
    push_word(midi_word({KIND_NOTE_OFF, 4'hA}, 7'd127, 7'd0, PANIC_LEN));
    push_word(bare_word(CMD_TICK));
    // fill the table, the last note-on is dropped but still takes over
    for (int n = 0; n < 9; n++) begin
      push_word(midi_word({KIND_NOTE_ON, 4'(n)}, 7'(20 + n), 7'(100 + n), PANIC_LEN));
    end
    push_word(bare_word(CMD_TICK));
    push_word(midi_word({KIND_NOTE_OFF, 4'h1}, 7'd28, 7'd5, 2'd1));
    push_word(midi_word({KIND_CTRL, 4'h2}, CC_ALL_OFF, 7'd0, 2'd2));
    push_word(bare_word(CMD_TICK));
    push_word(midi_word({KIND_CTRL, 4'h0}, CC_ALL_OFF, 7'd0, PANIC_LEN));
    push_word(bare_word(CMD_TICK));
    push_word(midi_word({KIND_NOTE_ON, 4'h9}, 7'd64, 7'd90, 2'd1));
    push_word(midi_word({KIND_SYSTEM, 4'h0}, 7'd64, 7'd10, 2'd1));
    push_word(midi_word({KIND_PRESSURE, 4'h0}, 7'd64, 7'd10, PANIC_LEN));
    push_word(bare_word(CMD_TICK));
    push_word(bare_word(CMD_PANIC));
    push_word(bare_word(CMD_IGNORED));
    push_word(bare_word(CMD_TICK));

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        in_valid <= 1'b0;
        while (tracker.cv_due.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        case (p)
          1: load_setting(8'h05, 8'h0C, 8'h64, 8'h01);
          2: load_setting(8'hFB, 8'hF4, 8'h9C, 8'h00);
          3: load_setting(8'hF8, 8'hF0, 8'h80, 8'hFF);
          4: load_setting(8'h07, 8'h0F, 8'h7F, 8'hFE);
          default: load_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        endcase
      end
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 77; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 77; end
        default: begin gap_pct = 31; stall_pct = 31; end
      endcase
      // hold off the receiver so the output word backs up into the input
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) push_word(rand_word());
    end
    in_valid <= 1'b0;

    while (tracker.cv_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

[sim.f]
rtl/mmcv_pkg.sv
rtl/mmcv_slot_cell.sv
rtl/mono_midi_note_to_cv_unit.sv
bench/tb_mono_midi_note_to_cv_unit.sv
